// ===== hdl/siphash_pow_solution_verifier_assert.svh =====
// Assertion macros used by the verifier's top-level RTL file.
`ifndef SIPHASH_POW_SOLUTION_VERIFIER_ASSERT_SVH
`define SIPHASH_POW_SOLUTION_VERIFIER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Clocked check that is switched off while reset is held.
`define SPPV_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define SPPV_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPPV_ASSERT(label, clk, rst_n, prop, msg)
`define SPPV_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== hdl/sppv_pkg.sv =====
// Types, constants and round functions for the SipHash proof-of-work verifier.
`timescale 1ns / 1ps

package sppv_pkg;

  // Initialisation words of the hash state.
  localparam logic [63:0] IV0 = 64'h736f6d6570736575;
  localparam logic [63:0] IV1 = 64'h646f72616e646f6d;
  localparam logic [63:0] IV2 = 64'h6c7967656e657261;
  localparam logic [63:0] IV3 = 64'h7465646279746573;

  // Output-length and finalisation tweaks for the 128-bit variant.
  localparam logic [63:0] WIDE_TWEAK = 64'h00000000000000ee;
  localparam logic [63:0] HIGH_TWEAK = 64'h00000000000000dd;

  // Final block word for an 8-byte message: the length in the top byte.
  localparam logic [63:0] TAIL_WORD = 64'h0800000000000000;

  // Register decode on the address bit that selects the 64-bit word.
  localparam logic REG_THR_LOW  = 1'b0;
  localparam logic REG_THR_HIGH = 1'b1;

  // The four 64-bit state words of one hash.
  typedef logic [3:0][63:0] sip_v_t;

  // Everything that travels down the cell chain for one item.
  typedef struct packed {
    sip_v_t      va;
    sip_v_t      vb;
    logic [63:0] msg_a;
    logic [63:0] msg_b;
    logic [63:0] lo_a;
    logic [63:0] lo_b;
  } item_t;

  // One half of a SipRound; the second half follows the first.
  function automatic sip_v_t sip_half(input sip_v_t v, input logic second);
    sip_v_t      r;
    logic [63:0] s0;
    logic [63:0] s2;
    r = v;
    if (!second) begin
      s0   = v[0] + v[1];
      s2   = v[2] + v[3];
      r[1] = {v[1][50:0], v[1][63:51]} ^ s0;
      r[0] = {s0[31:0], s0[63:32]};
      r[3] = {v[3][47:0], v[3][63:48]} ^ s2;
      r[2] = s2;
    end else begin
      s0   = v[0] + v[3];
      s2   = v[2] + v[1];
      r[3] = {v[3][42:0], v[3][63:43]} ^ s0;
      r[0] = s0;
      r[1] = {v[1][46:0], v[1][63:47]} ^ s2;
      r[2] = {s2[31:0], s2[63:32]};
    end
    return r;
  endfunction

  // Output word of the hash: all four state words folded together.
  function automatic logic [63:0] sip_fold(input sip_v_t v);
    return v[0] ^ v[1] ^ v[2] ^ v[3];
  endfunction

  // Full reversal of a 128-bit word.
  function automatic logic [127:0] bitrev128(input logic [127:0] x);
    logic [127:0] r;
    for (int i = 0; i < 128; i++) begin
      r[i] = x[127-i];
    end
    return r;
  endfunction

endpackage

// ===== hdl/sppv_cell.sv =====
// One cell of the hash chain: half a SipRound on both hashes, plus phase tweaks.
`timescale 1ns / 1ps

module sppv_cell #(
  parameter int STAGE           = 0,
  parameter int COMPRESS_ROUNDS = 2,
  parameter int FINAL_ROUNDS    = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           advance_i,
  input  logic           valid_i,
  input  sppv_pkg::item_t item_i,
  output logic           valid_o,
  output sppv_pkg::item_t item_o
);
  import sppv_pkg::*;

  localparam int ROUND = STAGE / 2;
  localparam int HALF  = STAGE % 2;

  logic  valid_q;
  item_t item_d;
  item_t item_q;

  // Tweaks that fall at the start of a round, then the half round itself.
  always_comb begin
    item_d = item_i;
    if (HALF == 0 && ROUND == COMPRESS_ROUNDS) begin
      // End of the message block and start of the length block.
      item_d.va[0] = item_d.va[0] ^ item_d.msg_a;
      item_d.vb[0] = item_d.vb[0] ^ item_d.msg_b;
      item_d.va[3] = item_d.va[3] ^ TAIL_WORD;
      item_d.vb[3] = item_d.vb[3] ^ TAIL_WORD;
    end
    if (HALF == 0 && ROUND == 2 * COMPRESS_ROUNDS) begin
      // End of the length block and start of finalisation.
      item_d.va[0] = item_d.va[0] ^ TAIL_WORD;
      item_d.vb[0] = item_d.vb[0] ^ TAIL_WORD;
      item_d.va[2] = item_d.va[2] ^ WIDE_TWEAK;
      item_d.vb[2] = item_d.vb[2] ^ WIDE_TWEAK;
    end
    if (HALF == 0 && ROUND == 2 * COMPRESS_ROUNDS + FINAL_ROUNDS) begin
      // Low output word is taken here; the high word needs more rounds.
      item_d.lo_a  = sip_fold(item_d.va);
      item_d.lo_b  = sip_fold(item_d.vb);
      item_d.va[1] = item_d.va[1] ^ HIGH_TWEAK;
      item_d.vb[1] = item_d.vb[1] ^ HIGH_TWEAK;
    end
    item_d.va = sip_half(item_d.va, HALF[0]);
    item_d.vb = sip_half(item_d.vb, HALF[0]);
  end

  // Valid flag of this cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  // Hash state of this cell.
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hdl/siphash_pow_solution_verifier.sv =====
// Top level of the SipHash proof-of-work solution verifier.
//
//  Port group      | Direction | Handshake               | Contents
//  in_*            | in        | in_valid_i / in_stall_o | nonce words, solution parts
//  out_*           | out       | out_valid_o / out_stall_i | passed flag, difficulty
//  APB             | in        | psel / penable / pready | 64-bit threshold words
//
// One item enters every cycle while the output side is not stalled.
// There is one cell per half SipRound, then one stage for the 128-bit sum and one
// for the compare. A stalled output freezes the whole chain, so the input stalls too.
// Reset clears all valid flags and both threshold words; there is no clearing pass.
`timescale 1ns / 1ps
`include "siphash_pow_solution_verifier_assert.svh"

module siphash_pow_solution_verifier #(
  parameter int COMPRESS_ROUNDS = 2,
  parameter int FINAL_ROUNDS    = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] nonce_low_i,
  input  logic [63:0] nonce_high_i,
  input  logic [31:0] solution_left_i,
  input  logic [47:0] solution_right_i,
  // Result item channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        passed_o,
  output logic [63:0] difficulty_low_o,
  output logic [63:0] difficulty_high_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import sppv_pkg::*;

  localparam int NUM_CELLS = 2 * (2 * COMPRESS_ROUNDS + 2 * FINAL_ROUNDS);

  logic          advance;
  logic [63:0]   thr_low_q;
  logic [63:0]   thr_high_q;
  logic [63:0]   key0_a;
  logic [63:0]   key0_b;
  item_t         init_item;
  logic          chain_valid [NUM_CELLS+1];
  item_t         chain_item  [NUM_CELLS+1];
  item_t         last_item;
  logic          sum_valid_q;
  logic [127:0]  sum_d;
  logic [127:0]  sum_q;
  logic [127:0]  diff_d;
  logic          passed_d;
  logic          out_valid_q;
  logic          passed_q;
  logic [127:0]  diff_q;

  // The chain moves unless a finished item waits on a stalled output.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign advance    = ~in_stall_o;

  // Threshold registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_low_q  <= '0;
      thr_high_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3])
        REG_THR_LOW:  thr_low_q  <= pwdata;
        REG_THR_HIGH: thr_high_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3])
      REG_THR_LOW:  prdata = thr_low_q;
      REG_THR_HIGH: prdata = thr_high_q;
      default:      prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Key set-up: the left hash has the top key bit forced high, the right low.
  assign key0_a = {1'b1, nonce_low_i[62:0]};
  assign key0_b = {1'b0, nonce_low_i[62:0]};

  always_comb begin
    init_item.msg_a = {32'd0, solution_left_i};
    init_item.msg_b = {16'd0, solution_right_i};
    init_item.va[0] = IV0 ^ key0_a;
    init_item.va[1] = IV1 ^ nonce_high_i ^ WIDE_TWEAK;
    init_item.va[2] = IV2 ^ key0_a;
    init_item.va[3] = IV3 ^ nonce_high_i ^ init_item.msg_a;
    init_item.vb[0] = IV0 ^ key0_b;
    init_item.vb[1] = IV1 ^ nonce_high_i ^ WIDE_TWEAK;
    init_item.vb[2] = IV2 ^ key0_b;
    init_item.vb[3] = IV3 ^ nonce_high_i ^ init_item.msg_b;
    init_item.lo_a  = '0;
    init_item.lo_b  = '0;
  end

  assign chain_valid[0] = in_valid_i;
  assign chain_item[0]  = init_item;

  // Row of cells, one per half round.
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    sppv_cell #(
      .STAGE           (g),
      .COMPRESS_ROUNDS (COMPRESS_ROUNDS),
      .FINAL_ROUNDS    (FINAL_ROUNDS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .valid_i   (chain_valid[g]),
      .item_i    (chain_item[g]),
      .valid_o   (chain_valid[g+1]),
      .item_o    (chain_item[g+1])
    );
  end

  assign last_item = chain_item[NUM_CELLS];

  // Sum of the two 128-bit hashes, modulo 2^128.
  assign sum_d = {sip_fold(last_item.va), last_item.lo_a}
               + {sip_fold(last_item.vb), last_item.lo_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (advance) begin
      sum_valid_q <= chain_valid[NUM_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sum_q <= sum_d;
    end
  end

  // Difficulty is the inverted sum read backwards; the compare is strict.
  assign diff_d   = bitrev128(~sum_q);
  assign passed_d = diff_d > {thr_high_q, thr_low_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= sum_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      passed_q <= passed_d;
      diff_q   <= diff_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign passed_o          = passed_q;
  assign difficulty_low_o  = diff_q[63:0];
  assign difficulty_high_o = diff_q[127:64];

  // Checks on the chain and the threshold registers.
  `SPPV_ASSERT_ALWAYS(a_reset_no_result, clk_i, !rst_ni |-> !out_valid_o, "result valid in reset")
  `SPPV_ASSERT(a_chain_to_sum, clk_i, rst_ni, advance && chain_valid[NUM_CELLS] |=> sum_valid_q, "item lost after last cell")
  `SPPV_ASSERT(a_sum_frozen, clk_i, rst_ni, !advance |=> $stable(sum_q) && $stable(sum_valid_q), "sum stage moved while frozen")
  `SPPV_ASSERT(a_thr_high_write, clk_i, rst_ni, psel && penable && pwrite && paddr[3] == REG_THR_HIGH |=> thr_high_q == $past(pwdata), "threshold write lost")

endmodule

// ===== tb/sv/siphash_pow_solution_verifier_test.sv =====
// Self-checking testbench for the SipHash proof-of-work solution verifier.
`timescale 1ns / 1ps

module siphash_pow_solution_verifier_test;
  import sppv_pkg::*;

  localparam int COMPRESS_ROUNDS = 2;
  localparam int FINAL_ROUNDS    = 4;
  localparam int LATENCY         = 2 * (2 * COMPRESS_ROUNDS + 2 * FINAL_ROUNDS) + 2;
  localparam int QUIET_LIMIT     = 2000;
  localparam int PHASE_ITEMS     = 130;
  localparam int PHASES          = 10;
  localparam int PRINT_CAP       = 40;

  localparam logic [3:0]  THR_LOW_ADDR  = {REG_THR_LOW, 3'b000};
  localparam logic [3:0]  THR_HIGH_ADDR = {REG_THR_HIGH, 3'b000};
  localparam logic [63:0] ALL_ONES      = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] SIGN_ONLY     = 64'h8000_0000_0000_0000;

  typedef logic [3:0][63:0] sip_state_t;

  typedef struct packed {
    logic        passed;
    logic [63:0] diff_low;
    logic [63:0] diff_high;
  } verdict_t;

  // Predicts each verdict and compares it with what the block returns.
  class verdict_scoreboard;
    logic [63:0] thr_low;
    logic [63:0] thr_high;
    verdict_t    verdicts_due[$];
    int unsigned candidates;
    int unsigned passes;
    int unsigned checked;
    int unsigned mismatches;

    function new();
      thr_low    = '0;
      thr_high   = '0;
      candidates = 0;
      passes     = 0;
      checked    = 0;
      mismatches = 0;
    endfunction

    function logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
      return (x << r) | (x >> (64 - r));
    endfunction

    // One full ARX round over the four state words.
    function sip_state_t sip_round(input sip_state_t s);
      sip_state_t v = s;
      v[0] = v[0] + v[1]; v[1] = rotl(v[1], 13); v[1] ^= v[0]; v[0] = rotl(v[0], 32);
      v[2] = v[2] + v[3]; v[3] = rotl(v[3], 16); v[3] ^= v[2];
      v[0] = v[0] + v[3]; v[3] = rotl(v[3], 21); v[3] ^= v[0];
      v[2] = v[2] + v[1]; v[1] = rotl(v[1], 17); v[1] ^= v[2]; v[2] = rotl(v[2], 32);
      return v;
    endfunction

    // Keyed hash of one 8-byte word with a 128-bit output, low word first.
    function logic [127:0] sip_hash128(input logic [63:0] k0, input logic [63:0] k1,
                                       input logic [63:0] msg);
      sip_state_t  v;
      logic [63:0] tail;
      logic [63:0] lo;
      tail = 64'h0800_0000_0000_0000;
      v[0] = 64'h736f6d6570736575 ^ k0;
      v[1] = 64'h646f72616e646f6d ^ k1 ^ 64'hee;
      v[2] = 64'h6c7967656e657261 ^ k0;
      v[3] = 64'h7465646279746573 ^ k1;
      // Message word, then the length-only final block.
      v[3] ^= msg;
      for (int r = 0; r < COMPRESS_ROUNDS; r++) v = sip_round(v);
      v[0] ^= msg;
      v[3] ^= tail;
      for (int r = 0; r < COMPRESS_ROUNDS; r++) v = sip_round(v);
      v[0] ^= tail;
      // Two finalisations give the two output words.
      v[2] ^= 64'hee;
      for (int r = 0; r < FINAL_ROUNDS; r++) v = sip_round(v);
      lo = v[0] ^ v[1] ^ v[2] ^ v[3];
      v[1] ^= 64'hdd;
      for (int r = 0; r < FINAL_ROUNDS; r++) v = sip_round(v);
      return {v[0] ^ v[1] ^ v[2] ^ v[3], lo};
    endfunction

    // Difficulty as {high word, low word}.
    function logic [127:0] difficulty_of(input logic [63:0] nl, input logic [63:0] nh,
                                         input logic [31:0] sl, input logic [47:0] sr);
      logic [127:0] left_hash;
      logic [127:0] right_hash;
      logic [127:0] folded;
      logic [127:0] mirrored;
      left_hash  = sip_hash128({1'b1, nl[62:0]}, nh, {32'd0, sl});
      right_hash = sip_hash128({1'b0, nl[62:0]}, nh, {16'd0, sr});
      folded     = ~(left_hash + right_hash);
      for (int i = 0; i < 128; i++) mirrored[i] = folded[127 - i];
      return mirrored;
    endfunction

    function void note_candidate(input logic [63:0] nl, input logic [63:0] nh,
                                 input logic [31:0] sl, input logic [47:0] sr);
      logic [127:0] d;
      verdict_t     v;
      d           = difficulty_of(nl, nh, sl, sr);
      v.diff_low  = d[63:0];
      v.diff_high = d[127:64];
      v.passed    = d > {thr_high, thr_low};
      if (v.passed) passes++;
      candidates++;
      verdicts_due = {verdicts_due, v};
    endfunction

    task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
      if (mismatches < PRINT_CAP) begin
        $display("%0t mismatch, %s: got %h, expected %h", $realtime, what, got, want);
      end
      mismatches++;
    endtask

    task check_verdict(input logic passed, input logic [63:0] dlo, input logic [63:0] dhi);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        report_mismatch("result with no candidate outstanding", dlo, '0);
      end else begin
        want = verdicts_due.pop_front();
        checked++;
        if (passed !== want.passed) begin
          report_mismatch("passed", {63'd0, passed}, {63'd0, want.passed});
        end
        if (dlo !== want.diff_low) report_mismatch("difficulty_low", dlo, want.diff_low);
        if (dhi !== want.diff_high) report_mismatch("difficulty_high", dhi, want.diff_high);
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] nonce_low_i = '0;
  logic [63:0] nonce_high_i = '0;
  logic [31:0] solution_left_i = '0;
  logic [47:0] solution_right_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        passed_o;
  logic [63:0] difficulty_low_o;
  logic [63:0] difficulty_high_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  verdict_scoreboard sb;
  int                bursty = 0;
  int                burst_left = 0;
  int                settings_applied = 0;
  int                stall_cycle = 0;
  int                quiet_cycles = 0;

  siphash_pow_solution_verifier dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .nonce_low_i      (nonce_low_i),
    .nonce_high_i     (nonce_high_i),
    .solution_left_i  (solution_left_i),
    .solution_right_i (solution_right_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .passed_o         (passed_o),
    .difficulty_low_o (difficulty_low_o),
    .difficulty_high_o(difficulty_high_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk_i = ~clk_i;

  // Monitors: note each accepted candidate and check each accepted verdict.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_candidate(nonce_low_i, nonce_high_i, solution_left_i, solution_right_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_verdict(passed_o, difficulty_low_o, difficulty_high_o);
    end
  end

  // Receiver stalls: free-flowing, light random, periodic and heavy random in turn.
  always @(posedge clk_i) begin
    stall_cycle++;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      case ((stall_cycle / 300) % 4)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 99) < 30);
        2: out_stall_i <= ((stall_cycle % 37) < 11);
        default: out_stall_i <= ($urandom_range(0, 99) < 70);
      endcase
    end
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timed out with %0d verdicts outstanding.", sb.verdicts_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Random field value with a fair share of all-zero and all-one words.
  function automatic logic [63:0] pick_field(input logic [63:0] mask);
    case ($urandom_range(0, 15))
      0: return '0;
      1: return mask;
      default: return {$urandom, $urandom} & mask;
    endcase
  endfunction

  // Present one candidate and hold it until it is taken.
  task automatic send_candidate(input logic [63:0] nl, input logic [63:0] nh,
                                input logic [31:0] sl, input logic [47:0] sr);
    if (bursty != 0 && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i       <= 1'b1;
    nonce_low_i      <= nl;
    nonce_high_i     <= nh;
    solution_left_i  <= sl;
    solution_right_i <= sr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stop sending and wait until every predicted verdict has been returned.
  task automatic wait_for_verdicts();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.verdicts_due.size() != 0) @(posedge clk_i);
  endtask

  // One APB transfer: setup cycle, access cycle, then an idle cycle.
  task automatic apb_access(input logic wr, input logic [3:0] addr, input logic [63:0] wdata,
                            output logic [63:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_thresholds();
    logic [63:0] back;
    apb_access(1'b0, THR_LOW_ADDR, '0, back);
    if (back !== sb.thr_low) sb.report_mismatch("threshold_low read", back, sb.thr_low);
    apb_access(1'b0, THR_HIGH_ADDR, '0, back);
    if (back !== sb.thr_high) sb.report_mismatch("threshold_high read", back, sb.thr_high);
  endtask

  task automatic apply_thresholds(input logic [63:0] lo, input logic [63:0] hi);
    logic [63:0] unused;
    apb_access(1'b1, THR_LOW_ADDR, lo, unused);
    apb_access(1'b1, THR_HIGH_ADDR, hi, unused);
    sb.thr_low  = lo;
    sb.thr_high = hi;
    settings_applied++;
    check_thresholds();
  endtask

  initial begin
    logic [127:0] target;
    logic [63:0]  f_nl;
    logic [63:0]  f_nh;
    logic [63:0]  f_sl;
    logic [63:0]  f_sr;
    // Reset goes low as a real transition so that the block's reset branch runs.
    rst_ni <= 1'b0;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Both threshold words must come out of reset as zero.
    check_thresholds();

    // Directed candidates at the extremes, under the zero threshold.
    send_candidate('0, '0, '0, '0);
    send_candidate(ALL_ONES, ALL_ONES, 32'hffff_ffff, 48'hffff_ffff_ffff);
    send_candidate(SIGN_ONLY, '0, '0, '0);
    send_candidate(~SIGN_ONLY, '0, 32'hffff_ffff, 48'hffff_ffff_ffff);
    send_candidate('0, '0, 32'hffff_ffff, '0);
    send_candidate('0, '0, '0, 48'hffff_ffff_ffff);
    send_candidate({4{16'h5555}}, {4{16'h5555}}, {2{16'haaaa}}, {3{16'haaaa}});
    send_candidate({4{16'haaaa}}, {4{16'haaaa}}, {2{16'h5555}}, {3{16'h5555}});
    send_candidate('0, ALL_ONES, '0, '0);
    send_candidate(64'h1, 64'h1, 32'h1, 48'h1);
    send_candidate(64'h0123_4567_89ab_cdef, '0, 32'h1, 48'h8000_0000_0000);
    wait_for_verdicts();

    // Thresholds at, just below and just above one known difficulty.
    target = sb.difficulty_of(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                              32'hdead_beef, 48'h1234_5678_9abc);
    for (int k = 0; k < 5; k++) begin
      case (k)
        0: apply_thresholds(target[63:0], target[127:64]);
        1: apply_thresholds(target[63:0] - 64'd1, target[127:64]);
        2: apply_thresholds(target[63:0] + 64'd1, target[127:64]);
        3: apply_thresholds(target[63:0], target[127:64] - 64'd1);
        default: apply_thresholds(target[63:0], target[127:64] + 64'd1);
      endcase
      send_candidate(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                     32'hdead_beef, 48'h1234_5678_9abc);
      wait_for_verdicts();
    end

    // Random candidates over a sequence of threshold settings.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_thresholds(ALL_ONES, ALL_ONES);
        1: apply_thresholds('0, '0);
        2: apply_thresholds('0, SIGN_ONLY);
        3: apply_thresholds(ALL_ONES, ~SIGN_ONLY);
        4: apply_thresholds(ALL_ONES, '0);
        default: apply_thresholds({$urandom, $urandom}, {$urandom, $urandom});
      endcase
      bursty = (p % 3 != 0) ? 1 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Let the pipeline empty completely once in mid-stream.
        if (p == 2 && i == PHASE_ITEMS / 2) wait_for_verdicts();
        f_nl = pick_field(ALL_ONES);
        f_nh = pick_field(ALL_ONES);
        f_sl = pick_field(64'hffff_ffff);
        f_sr = pick_field(64'hffff_ffff_ffff);
        send_candidate(f_nl, f_nh, f_sl[31:0], f_sr[47:0]);
      end
      wait_for_verdicts();
    end

    // Allow any stray verdict to surface.
    repeat (2 * LATENCY) @(posedge clk_i);

    $display("Sent %0d candidates (%0d above threshold) over %0d threshold settings.",
             sb.candidates, sb.passes, settings_applied);
    $display("Compared %0d verdicts under bursty input and four receiver stall patterns.",
             sb.checked);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
